// ----- rtl/lra_pkg.sv -----
// ----------------------------------------------------------------------------
// Label region accumulator package
// Shared widths, codes, the queue word type and the exponent table.
// ----------------------------------------------------------------------------
package lra_pkg;

   // Store geometry and limits.
   localparam int unsigned LABEL_COUNT     = 256;
   localparam int unsigned LABEL_W         = $clog2(LABEL_COUNT);
   localparam int unsigned MAX_VOXELS      = 16777216;
   localparam int unsigned COUNT_W         = 25;
   localparam int unsigned SUM_W           = 48;
   localparam int unsigned VALUE_W         = 24;
   localparam int unsigned VOLUME_W        = 24;
   localparam int unsigned MEAN_W          = 24;
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Exponent table geometry (depth is a power of two).
   localparam int unsigned EXP_TABLE_DEPTH = 64;
   localparam int unsigned EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
   localparam int unsigned EXP_REM_W       = 16 - EXP_IDX_W;
   localparam int unsigned MANT_W          = 18;
   localparam longint unsigned LN2_Q30     = 64'd744261118;
   localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Commands of the request channel.
   localparam logic [1:0] CMD_ACC   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Modes.
   localparam logic [1:0] MODE_SUMS   = 2'd0;
   localparam logic [1:0] MODE_MEANS  = 2'd1;
   localparam logic [1:0] MODE_JACOB  = 2'd2;
   localparam logic [1:0] MODE_LABELS = 2'd3;

   // Register indexes.
   localparam logic REG_MODE   = 1'b0;
   localparam logic REG_VOLUME = 1'b1;

   // Operation kinds passed from front to back.
   localparam logic [1:0] OP_ACC   = 2'd0;
   localparam logic [1:0] OP_DROP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]          kind;
      logic [LABEL_W-1:0]  label;
      logic [SUM_W-1:0]    weight;
   } op_entry_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [VOLUME_W-1:0] volume;
   } cfg_type;

   typedef struct packed {
      logic                sat;
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    sum;
   } store_entry_type;

   typedef logic [EXP_TABLE_DEPTH:0][MANT_W-1:0] exp_rom_type;

   // Shift-and-subtract quotient for the table build (small divisors).
   function automatic longint unsigned div_small(longint unsigned num,
                                                 longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Q16 table of 2^(i/depth), built from a Taylor series in Q30.
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      longint unsigned t;
      longint unsigned term;
      longint unsigned acc;
      for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
         t    = (longint'(i) * LN2_Q30) >> EXP_IDX_W;
         term = 64'd1 << 30;
         acc  = term;
         for (int k = 1; k <= 24; k++) begin
            term = div_small((term * t) >> 30, longint'(k));
            acc  = acc + term;
         end
         rom[i] = MANT_W'((acc + 64'd8192) >> 14);
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

// ----- rtl/lra_front.sv -----
// ----------------------------------------------------------------------------
// Label region accumulator front end
// Accepts request words, classifies them and computes the weight to add.
// ----------------------------------------------------------------------------
module lra_front (
   input  logic                           clock,
   input  logic                           reset,
   input  lra_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic [lra_pkg::LABEL_W-1:0]    req_label,
   input  logic [lra_pkg::VALUE_W-1:0]    req_voxel_value,
   output logic                           push,
   output lra_pkg::op_entry_type          push_entry,
   input  logic                           queue_full
);
   import lra_pkg::*;

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_X2   = 3'd1;
   localparam logic [2:0] F_X3   = 3'd2;
   localparam logic [2:0] F_X4   = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic [2:0]               state_ff, state_in;
   op_entry_type             entry_ff, entry_in;
   logic signed [41:0]       p_ff, p_in;
   logic [MANT_W-1:0]        lo_ff, lo_in;
   logic [33:0]              interp_ff, interp_in;
   logic signed [9:0]        n_ff, n_in;
   logic [41:0]              prod_ff, prod_in;

   logic                     accept;
   logic [24:0]              rpos;
   logic                     lbl3_ok;
   logic [LABEL_W-1:0]       lbl3;
   logic [15:0]              frac;
   logic [EXP_IDX_W-1:0]     idx;
   logic [EXP_IDX_W:0]       idx_hi;
   logic [15:0]              rem16;
   logic [MANT_W-1:0]        hi;
   logic [MANT_W-1:0]        mant;
   logic signed [10:0]       shift_s;
   logic [10:0]              rshift;
   logic [89:0]              wide;
   logic [63:0]              rsum;
   logic [SUM_W-1:0]         exp_w;

   assign req_stall  = (state_ff != F_IDLE);
   assign accept     = req_valid && !req_stall;
   assign push       = (state_ff == F_PUSH) && !queue_full;
   assign push_entry = entry_ff;

   // Label taken from the voxel value, rounded half away from zero.
   always_comb begin
      rpos = {1'b0, req_voxel_value} + 25'h8000;
      if (!req_voxel_value[VALUE_W-1]) begin
         lbl3_ok = rpos[24:16] < 9'(LABEL_COUNT);
      end else begin
         lbl3_ok = $signed(req_voxel_value) > -24'sd32768;
      end
      lbl3 = req_voxel_value[VALUE_W-1] ? '0 : LABEL_W'(rpos[24:16]);
   end

   // Table interpolation of the fraction of the base-2 exponent.
   always_comb begin
      frac      = p_ff[31:16];
      idx       = frac[15 -: EXP_IDX_W];
      idx_hi    = {1'b0, idx} + 1'b1;
      rem16     = {frac[EXP_REM_W-1:0], {EXP_IDX_W{1'b0}}};
      lo_in     = EXP_ROM[{1'b0, idx}];
      hi        = EXP_ROM[idx_hi];
      interp_in = 34'(hi - lo_in) * 34'(rem16);
      n_in      = p_ff[41:32];
      mant      = lo_ff + MANT_W'((interp_ff + 34'h8000) >> 16);
      prod_in   = 42'(mant) * 42'(cfg.volume);
   end

   // Scale the product by 2^(n-16) with rounding and saturation.
   always_comb begin
      shift_s = $signed({n_ff[9], n_ff}) - 11'sd16;
      rshift  = 11'(-shift_s);
      wide    = {48'b0, prod_ff} << shift_s[5:0];
      rsum    = ({22'b0, prod_ff} + (64'd1 << (rshift[5:0] - 6'd1))) >> rshift[5:0];
      if (prod_ff == '0) begin
         exp_w = '0;
      end else if (!shift_s[10]) begin
         if (shift_s >= 11'sd48 || (|wide[89:47])) begin
            exp_w = SUM_MAX;
         end else begin
            exp_w = wide[47:0];
         end
      end else if (rshift > 11'd62) begin
         exp_w = '0;
      end else begin
         exp_w = rsum[47:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      p_in     = $signed(req_voxel_value) * LOG2E_Q16;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               entry_in.label  = req_label;
               entry_in.weight = SUM_W'($signed(req_voxel_value));
               state_in        = F_PUSH;
               case (req_command)
                  CMD_ACC: begin
                     if (cfg.mode == MODE_LABELS) begin
                        entry_in.kind   = lbl3_ok ? OP_ACC : OP_DROP;
                        entry_in.label  = lbl3;
                        entry_in.weight = SUM_W'(cfg.volume);
                     end else if ({1'b0, req_label} >= (LABEL_W+1)'(LABEL_COUNT)) begin
                        entry_in.kind = OP_DROP;
                     end else begin
                        entry_in.kind = OP_ACC;
                        if (cfg.mode == MODE_JACOB) begin
                           state_in = F_X2;
                        end
                     end
                  end
                  CMD_READ:  entry_in.kind = OP_READ;
                  CMD_CLEAR: entry_in.kind = OP_CLEAR;
                  default:   state_in = F_IDLE;
               endcase
            end
         end
         F_X2: state_in = F_X3;
         F_X3: state_in = F_X4;
         F_X4: begin
            entry_in.weight = exp_w;
            state_in        = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      entry_ff  <= entry_in;
      if (accept) begin
         p_ff <= p_in;
      end
      lo_ff     <= lo_in;
      interp_ff <= interp_in;
      n_ff      <= n_in;
      prod_ff   <= prod_in;
   end

endmodule

// ----- rtl/lra_queue.sv -----
// ----------------------------------------------------------------------------
// Label region accumulator operation queue
// Short first-in first-out buffer between the front end and the store.
// ----------------------------------------------------------------------------
module lra_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lra_pkg::op_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output lra_pkg::op_entry_type pop_entry
);
   import lra_pkg::*;

   op_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_entry = slot_ff[rd_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/lra_back.sv -----
// ----------------------------------------------------------------------------
// Label region accumulator back end
// Owns the label store, performs updates, readouts, the mean division.
// ----------------------------------------------------------------------------
module lra_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   input  lra_pkg::op_entry_type          pop_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lra_pkg::LABEL_W-1:0]    rsp_read_label,
   output logic [lra_pkg::COUNT_W-1:0]    rsp_voxel_count,
   output logic [lra_pkg::SUM_W-1:0]      rsp_label_sum,
   output logic [lra_pkg::MEAN_W-1:0]     rsp_label_mean,
   output logic                           rsp_saturated,
   output logic                           rsp_range_error
);
   import lra_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_UPD  = 3'd1;
   localparam logic [2:0] B_RDAT = 3'd2;
   localparam logic [2:0] B_DIV  = 3'd3;
   localparam logic [2:0] B_FIN  = 3'd4;
   localparam int unsigned STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

   store_entry_type        mem [LABEL_COUNT];
   store_entry_type        rd_ff;
   logic                   rd_valid_ff;
   logic [LABEL_COUNT-1:0] valid_ff, valid_in;
   logic                   range_flag_ff, range_flag_in;
   logic [2:0]             state_ff, state_in;
   op_entry_type           cur_ff, cur_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   sat_ff, sat_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;
   logic [SUM_W-1:0]       dvd_ff, dvd_in;
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   out_valid_ff;
   logic [LABEL_W-1:0]     out_label_ff;
   logic [COUNT_W-1:0]     out_count_ff;
   logic [SUM_W-1:0]       out_sum_ff;
   logic [MEAN_W-1:0]      out_mean_ff;
   logic                   out_sat_ff;
   logic                   out_range_ff;

   store_entry_type        ent;
   store_entry_type        wr_data;
   logic                   we;
   logic [SUM_W:0]         sum_wide;
   logic [COUNT_W:0]       trial;
   logic                   ge;
   logic                   round_up;
   logic [SUM_W:0]         q_round;
   logic [MEAN_W:0]        q_clamp;
   logic [MEAN_W-1:0]      mean;
   logic                   load;

   assign ent = rd_valid_ff ? rd_ff : '0;

   // Saturating add and count step for an accumulate.
   always_comb begin
      sum_wide      = {ent.sum[SUM_W-1], ent.sum} + {cur_ff.weight[SUM_W-1], cur_ff.weight};
      wr_data       = ent;
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         wr_data.sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
         wr_data.sat = 1'b1;
      end else begin
         wr_data.sum = sum_wide[SUM_W-1:0];
      end
      if (ent.count < COUNT_W'(MAX_VOXELS)) begin
         wr_data.count = ent.count + 1'b1;
      end
   end

   // One restoring division step per cycle.
   always_comb begin
      trial = {rem_ff, dvd_ff[SUM_W-1]};
      ge    = trial >= {1'b0, count_ff};
   end

   // Mean from quotient and remainder, rounded and clamped to Q8.16.
   always_comb begin
      round_up = {rem_ff, 1'b0} >= {1'b0, count_ff};
      q_round  = {1'b0, dvd_ff} + (SUM_W+1)'(round_up);
      if (q_round > (SUM_W+1)'(25'h800000)) begin
         q_clamp = 25'h800000;
      end else begin
         q_clamp = q_round[MEAN_W:0];
      end
      if (zero_ff) begin
         mean = '0;
      end else if (neg_ff) begin
         mean = MEAN_W'(-q_clamp);
      end else if (q_clamp[MEAN_W-1]) begin
         mean = 24'h7FFFFF;
      end else begin
         mean = q_clamp[MEAN_W-1:0];
      end
   end

   assign load = (state_ff == B_FIN) && (!out_valid_ff || !rsp_stall);

   // Store sequencer.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      valid_in      = valid_ff;
      range_flag_in = range_flag_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      pop           = 1'b0;
      we            = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               pop    = 1'b1;
               cur_in = pop_entry;
               unique case (pop_entry.kind)
                  OP_ACC:   state_in = B_UPD;
                  OP_READ:  state_in = B_RDAT;
                  OP_DROP:  range_flag_in = 1'b1;
                  OP_CLEAR: begin
                     valid_in      = '0;
                     range_flag_in = 1'b0;
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_UPD: begin
            we                     = 1'b1;
            valid_in[cur_ff.label] = 1'b1;
            state_in               = B_IDLE;
         end
         B_RDAT: begin
            count_in = ent.count;
            sum_in   = ent.sum;
            sat_in   = ent.sat;
            neg_in   = ent.sum[SUM_W-1];
            zero_in  = (ent.count == '0);
            dvd_in   = ent.sum[SUM_W-1] ? SUM_W'(-ent.sum) : ent.sum;
            rem_in   = '0;
            step_in  = '0;
            state_in = (ent.count == '0) ? B_FIN : B_DIV;
         end
         B_DIV: begin
            rem_in  = ge ? COUNT_W'(trial - {1'b0, count_ff}) : COUNT_W'(trial);
            dvd_in  = {dvd_ff[SUM_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (load) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Label store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[cur_ff.label] <= wr_data;
      end
      rd_ff       <= mem[pop_entry.label];
      rd_valid_ff <= valid_ff[pop_entry.label];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         valid_ff      <= '0;
         range_flag_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         range_flag_ff <= range_flag_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      cur_ff   <= cur_in;
      count_ff <= count_in;
      sum_ff   <= sum_in;
      sat_ff   <= sat_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      if (load) begin
         out_label_ff <= cur_ff.label;
         out_count_ff <= count_ff;
         out_sum_ff   <= sum_ff;
         out_mean_ff  <= mean;
         out_sat_ff   <= sat_ff;
         out_range_ff <= range_flag_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_label  = out_label_ff;
   assign rsp_voxel_count = out_count_ff;
   assign rsp_label_sum   = out_sum_ff;
   assign rsp_label_mean  = out_mean_ff;
   assign rsp_saturated   = out_sat_ff;
   assign rsp_range_error = out_range_ff;

`ifndef SYNTHESIS
   // The division runs exactly one step per quotient bit.
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV && step_ff == DIV_LAST) |=> (state_ff == B_FIN))
      else $error("division did not finish after its last step");

   // A clear empties the store and the range flag.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE && pop_valid && pop_entry.kind == OP_CLEAR)
      |=> (valid_ff == '0 && !range_flag_ff))
      else $error("clear left store entries or range flag set");

   // An update marks its entry as written.
   a_upd_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_UPD) |=> valid_ff[$past(cur_ff.label)])
      else $error("updated entry not marked valid");

   // A result is only loaded at the end of a readout.
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == B_FIN))
      else $error("result loaded outside a readout");
`endif

endmodule

// ----- rtl/label_region_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// Label region accumulator core
// Per-label count, saturating sum and mean over a stream of voxel words.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_) takes accumulate, read and clear words; an
// accumulate or clear gives no result, a read gives one word on rsp_.
// The csr_ port writes mode and voxel volume; the user must write it only
// while the block is idle, as the block itself does not enforce it. The
// front sequencer and the store's read-modify-write pace the requests: an
// accumulate goes through the front's push state (in jacobian mode first
// through the three exponent stages) and takes a read and an update at the
// store port; a clear or a drop is handled by the store as it is popped.
// A read holds the store until its result is loaded, since the mean uses a
// one-bit-per-cycle divider over the 48-bit sum, skipped for a zero count.
// A two-word queue lets the front accept while the store is busy.
// Reset clears the whole store at once (per-entry valid bits), the range
// flag and the registers (mode sums, volume 1.0). While rsp_stall is high
// the result word holds, the next read result waits at the store, and the
// queue and then req_stall fill behind it.
// ----------------------------------------------------------------------------
module label_region_accumulator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic                           csr_index,
   input  logic [lra_pkg::VOLUME_W-1:0]   csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic [lra_pkg::LABEL_W-1:0]    req_label,
   input  logic [lra_pkg::VALUE_W-1:0]    req_voxel_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lra_pkg::LABEL_W-1:0]    rsp_read_label,
   output logic [lra_pkg::COUNT_W-1:0]    rsp_voxel_count,
   output logic [lra_pkg::SUM_W-1:0]      rsp_label_sum,
   output logic [lra_pkg::MEAN_W-1:0]     rsp_label_mean,
   output logic                           rsp_saturated,
   output logic                           rsp_range_error
);
   import lra_pkg::*;

   logic [1:0]          mode_ff;
   logic [VOLUME_W-1:0] volume_ff;
   cfg_type             cfg;
   logic                push;
   op_entry_type        push_entry;
   logic                queue_full;
   logic                pop;
   logic                pop_valid;
   op_entry_type        pop_entry;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SUMS;
         volume_ff <= 24'd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_MODE:   mode_ff   <= csr_write_data[1:0];
            REG_VOLUME: volume_ff <= csr_write_data;
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   assign cfg.mode   = mode_ff;
   assign cfg.volume = volume_ff;

   lra_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_label       (req_label),
      .req_voxel_value (req_voxel_value),
      .push            (push),
      .push_entry      (push_entry),
      .queue_full      (queue_full)
   );

   lra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   lra_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_label  (rsp_read_label),
      .rsp_voxel_count (rsp_voxel_count),
      .rsp_label_sum   (rsp_label_sum),
      .rsp_label_mean  (rsp_label_mean),
      .rsp_saturated   (rsp_saturated),
      .rsp_range_error (rsp_range_error)
   );

endmodule
